FILE: src/nrt_pkg.sv
// shared types, constants and helpers for the neighbor reachability tracker
// used by every module of the block; depends on nothing
package nrt_pkg;

  localparam int ENTRIES = 16;
  localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // request kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_ACK    = 2'd2;
  localparam logic [1:0] KIND_CHECK  = 2'd3;

  // reachability states
  localparam logic [2:0] ST_INCOMPLETE = 3'd0;
  localparam logic [2:0] ST_REACHABLE  = 3'd1;
  localparam logic [2:0] ST_STALE      = 3'd2;
  localparam logic [2:0] ST_DELAY      = 3'd3;
  localparam logic [2:0] ST_PROBE      = 3'd4;

  // result actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_MCAST = 2'd1;
  localparam logic [1:0] ACT_UCAST = 2'd2;
  localparam logic [1:0] ACT_DROP  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_REACHABLE = 2'd0;
  localparam logic [1:0] REG_RETRANS   = 2'd1;
  localparam logic [1:0] REG_MAX_MCAST = 2'd2;
  localparam logic [1:0] REG_MAX_UCAST = 2'd3;

  localparam logic [15:0] REACHABLE_RESET = 16'd30;
  localparam logic [15:0] RETRANS_RESET   = 16'd1;
  localparam logic [3:0]  MAX_MCAST_RESET = 4'd3;
  localparam logic [3:0]  MAX_UCAST_RESET = 4'd3;

  localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;

  typedef enum logic {
    PH_IDLE,
    PH_EXEC
  } nrt_phase_t;

  typedef struct packed {
    logic [2:0]  state;
    logic [31:0] reach_dl;
    logic [31:0] retx_dl;
    logic [3:0]  count;
  } nrt_rec_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  entry;
    logic [2:0]  new_state;
    logic [31:0] now;
    logic        tx_idle;
  } nrt_req_t;

  typedef struct packed {
    logic [15:0] reachable_seconds;
    logic [15:0] retrans_seconds;
    logic [3:0]  max_mcast;
    logic [3:0]  max_ucast;
  } nrt_cfg_t;

  typedef struct packed {
    logic     valid_we;
    logic     valid_next;
    logic     rec_we;
    nrt_rec_t rec;
  } nrt_upd_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] state;
    logic [1:0] action;
    logic       chk;
    logic [3:0] count;
  } nrt_res_t;

  // wrap-safe "now at or after deadline"
  function automatic logic expired(input logic [31:0] now, input logic [31:0] deadline);
    logic [31:0] diff;
    diff = now - deadline;
    return diff < HALF_RANGE;
  endfunction

endpackage

FILE: src/neighbor_reachability_tracker_core.sv
// top level of the neighbor reachability tracker: request control, valid marks,
// configuration registers and result register; depends on nrt_pkg,
// nrt_entry_store and nrt_step
//
// usage
//   a request is taken on a clock edge where start is high and busy is low; it
//   addresses one entry (add, remove, link ack or periodic check)
//   the entry record is read from the entry memory on that edge; in the next
//   cycle busy is high while the record is updated and written back
//   the result beat appears on the result ports in the following cycle, with done high
//   for exactly that cycle
//   a new request is not taken while busy is high, set by the read then write of
//   the single-port-per-direction entry memory; the accept may coincide with
//   the done beat of the previous request
//   results cannot be held off: the receiver takes each beat as it comes
//   configuration beats use cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is high whenever no request is in progress
//   reset (rst, synchronous) clears all valid marks, sets the configuration
//   registers to their defaults and drops busy and done; no clearing pass
module neighbor_reachability_tracker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [3:0]  entry,
  input  logic [2:0]  new_state,
  input  logic [31:0] now_seconds,
  input  logic        tx_idle,
  output logic        done,
  output logic        entry_valid,
  output logic [2:0]  entry_state,
  output logic [1:0]  action,
  output logic        check_default_router,
  output logic [3:0]  solicit_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import nrt_pkg::*;

  nrt_phase_t phase, phase_next;
  logic       accept;

  nrt_req_t   req;
  nrt_rec_t   rd_rec;
  nrt_cfg_t   cfg;
  nrt_upd_t   upd;
  nrt_res_t   res;
  logic [ENTRY_W-1:0] rd_addr;
  logic [ENTRY_W-1:0] idx;
  logic [ENTRIES-1:0] valid_marks;
  logic       cur_valid;

  logic [15:0] reachable_seconds;
  logic [15:0] retrans_seconds;
  logic [3:0]  max_mcast;
  logic [3:0]  max_ucast;

  // phase control
  always_comb begin
    case (phase)
      PH_IDLE: phase_next = start ? PH_EXEC : PH_IDLE;
      PH_EXEC: phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    case (phase)
      PH_IDLE: busy = 1'b0;
      PH_EXEC: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  assign accept    = start & ~busy;
  assign cfg_ready = ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req.kind      <= kind;
      req.entry     <= entry;
      req.new_state <= new_state;
      req.now       <= now_seconds;
      req.tx_idle   <= tx_idle;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reachable_seconds <= REACHABLE_RESET;
      retrans_seconds   <= RETRANS_RESET;
      max_mcast         <= MAX_MCAST_RESET;
      max_ucast         <= MAX_UCAST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REACHABLE: reachable_seconds <= cfg_data;
        REG_RETRANS:   retrans_seconds   <= cfg_data;
        REG_MAX_MCAST: max_mcast         <= cfg_data[3:0];
        REG_MAX_UCAST: max_ucast         <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{reachable_seconds: reachable_seconds,
                 retrans_seconds:   retrans_seconds,
                 max_mcast:         max_mcast,
                 max_ucast:         max_ucast};

  assign rd_addr = ENTRY_W'(entry);
  assign idx     = ENTRY_W'(req.entry);

  nrt_entry_store u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_rec),
    .wr_en   (busy & upd.rec_we),
    .wr_addr (idx),
    .wr_data (upd.rec)
  );

  // out-of-range indexes are masked inside the step logic
  assign cur_valid = valid_marks[idx];

  nrt_step u_step (
    .req   (req),
    .rec   (rd_rec),
    .valid (cur_valid),
    .cfg   (cfg),
    .upd   (upd),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_marks <= '0;
    end else if (busy && upd.valid_we) begin
      valid_marks[idx] <= upd.valid_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      entry_valid          <= res.valid;
      entry_state          <= res.state;
      action               <= res.action;
      check_default_router <= res.chk;
      solicit_count        <= res.count;
    end
  end

endmodule

FILE: src/nrt_entry_store.sv
// entry record memory: one write port, one read port, registered read data
// depends on nrt_pkg
module nrt_entry_store (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [nrt_pkg::ENTRY_W-1:0] rd_addr,
  output nrt_pkg::nrt_rec_t     rd_data,
  input  logic                  wr_en,
  input  logic [nrt_pkg::ENTRY_W-1:0] wr_addr,
  input  nrt_pkg::nrt_rec_t     wr_data
);
  import nrt_pkg::*;

  nrt_rec_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/nrt_step.sv
// update logic for one entry: applies a request to the record read from memory
// depends on nrt_pkg
module nrt_step (
  input  nrt_pkg::nrt_req_t req,
  input  nrt_pkg::nrt_rec_t rec,
  input  logic              valid,
  input  nrt_pkg::nrt_cfg_t cfg,
  output nrt_pkg::nrt_upd_t upd,
  output nrt_pkg::nrt_res_t res
);
  import nrt_pkg::*;

  logic       in_range;
  logic       probing;
  logic [3:0] limit;
  logic [1:0] action;
  logic       chk;
  logic       out_valid;

  assign in_range = 32'(req.entry) < ENTRIES;
  assign probing  = (rec.state == ST_PROBE);
  assign limit    = probing ? cfg.max_ucast : cfg.max_mcast;

  always_comb begin
    upd.valid_we   = in_range;
    upd.valid_next = valid;
    upd.rec_we     = 1'b0;
    upd.rec        = rec;
    action         = ACT_NONE;
    chk            = 1'b0;
    if (in_range) begin
      case (req.kind)
        KIND_ADD: begin
          if (req.new_state <= ST_PROBE) begin
            upd.valid_next = 1'b1;
            upd.rec_we     = 1'b1;
            upd.rec.state  = req.new_state;
            upd.rec.reach_dl = req.now;
            upd.rec.retx_dl  = req.now;
            upd.rec.count    = 4'd0;
          end
        end
        KIND_REMOVE: begin
          upd.valid_next = 1'b0;
        end
        KIND_ACK: begin
          if (valid && (rec.state == ST_STALE || rec.state == ST_DELAY ||
                        rec.state == ST_PROBE)) begin
            upd.rec_we       = 1'b1;
            upd.rec.state    = ST_REACHABLE;
            upd.rec.reach_dl = req.now + 32'(cfg.reachable_seconds);
          end
        end
        KIND_CHECK: begin
          if (valid) begin
            case (rec.state)
              ST_REACHABLE: begin
                if (expired(req.now, rec.reach_dl)) begin
                  upd.rec_we    = 1'b1;
                  upd.rec.state = ST_STALE;
                end
              end
              ST_DELAY: begin
                if (expired(req.now, rec.reach_dl)) begin
                  upd.rec_we      = 1'b1;
                  upd.rec.state   = ST_PROBE;
                  upd.rec.count   = 4'd0;
                  upd.rec.retx_dl = req.now;
                end
              end
              ST_INCOMPLETE, ST_PROBE: begin
                if (rec.count >= limit) begin
                  upd.valid_next = 1'b0;
                  action         = ACT_DROP;
                  chk            = probing;
                end else if (expired(req.now, rec.retx_dl) && req.tx_idle) begin
                  upd.rec_we      = 1'b1;
                  upd.rec.count   = rec.count + 4'd1;
                  upd.rec.retx_dl = req.now + 32'(cfg.retrans_seconds);
                  action          = probing ? ACT_UCAST : ACT_MCAST;
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = in_range & upd.valid_next;

  always_comb begin
    res.valid  = out_valid;
    res.state  = out_valid ? upd.rec.state : ST_INCOMPLETE;
    res.count  = out_valid ? upd.rec.count : 4'd0;
    res.action = action;
    res.chk    = chk;
  end

endmodule

FILE: src/nrt_checker.sv
// port-level checks on the neighbor reachability tracker, bound to the top level
// depends on nrt_pkg and neighbor_reachability_tracker_core
module nrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        entry_valid,
  input logic [2:0]  entry_state,
  input logic [1:0]  action,
  input logic        check_default_router,
  input logic [3:0]  solicit_count
);
  import nrt_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("update cycle not followed by a single result beat");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without an update cycle");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && !entry_valid |-> entry_state == ST_INCOMPLETE && solicit_count == 4'd0)
    else $error("invalid entry reported with state or count");

  a_router_drop: assert property (@(posedge clk) disable iff (rst)
    done && check_default_router |-> action == ACT_DROP && !entry_valid)
    else $error("router check without a drop");

endmodule

bind neighbor_reachability_tracker_core nrt_checker u_nrt_checker (.*);

FILE: dv/nrt_tracker_checker.sv
// result checker for the neighbour reachability tracker: keeps its own table of
// entries and timer settings, predicts each result beat and compares it on arrival
// depends on nrt_pkg for the table size, the reset settings and the state, kind, action and register codes
module nrt_tracker_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  kind,
  input  logic [3:0]  entry,
  input  logic [2:0]  new_state,
  input  logic [31:0] now_seconds,
  input  logic        tx_idle,
  input  logic        done,
  input  logic        entry_valid,
  input  logic [2:0]  entry_state,
  input  logic [1:0]  action,
  input  logic        check_default_router,
  input  logic [3:0]  solicit_count,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          solicits_seen,
  output int          drops_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import nrt_pkg::*;

  typedef struct packed {
    logic       valid;
    logic [2:0] state;
    logic [1:0] action;
    logic       chk;
    logic [3:0] count;
  } nbr_outcome_t;

  nbr_outcome_t outcome_q[$];

  bit        valid_tbl[ENTRIES];
  bit [2:0]  state_tbl[ENTRIES];
  bit [31:0] reach_dl_tbl[ENTRIES];
  bit [31:0] retx_dl_tbl[ENTRIES];
  bit [3:0]  count_tbl[ENTRIES];

  bit [15:0] reach_secs;
  bit [15:0] retx_secs;
  bit [3:0]  mcast_limit;
  bit [3:0]  ucast_limit;

  task automatic report_fault(input string msg);
    $display("%0t ns checker: %s", $time, msg);
    fail_count++;
  endtask

  // wrap-safe: t at or after d when the difference t - d is below 7FFF_FFFF
  function automatic bit deadline_passed(input bit [31:0] t, input bit [31:0] d);
    bit [31:0] gap;
    gap = t - d;
    return gap < 32'h7FFF_FFFF;
  endfunction

  task automatic step_entry(input logic [1:0] k, input logic [3:0] idx,
                            input logic [2:0] nst, input logic [31:0] t,
                            input logic idle, output nbr_outcome_t res);
    bit [2:0] cur;
    bit [3:0] limit;
    bit       probing;
    res = '0;
    case (k)
      KIND_ADD: begin
        // unknown state codes leave the entry alone
        if (nst <= ST_PROBE) begin
          valid_tbl[idx]    = 1'b1;
          state_tbl[idx]    = nst;
          reach_dl_tbl[idx] = t;
          retx_dl_tbl[idx]  = t;
          count_tbl[idx]    = '0;
        end
      end
      KIND_REMOVE: valid_tbl[idx] = 1'b0;
      default: begin
        if (valid_tbl[idx]) begin
          cur = state_tbl[idx];
          if (k == KIND_ACK) begin
            if (cur == ST_STALE || cur == ST_DELAY || cur == ST_PROBE) begin
              state_tbl[idx]    = ST_REACHABLE;
              reach_dl_tbl[idx] = t + reach_secs;
            end
          end else begin
            case (cur)
              ST_REACHABLE: begin
                if (deadline_passed(t, reach_dl_tbl[idx])) state_tbl[idx] = ST_STALE;
              end
              ST_DELAY: begin
                if (deadline_passed(t, reach_dl_tbl[idx])) begin
                  state_tbl[idx]   = ST_PROBE;
                  count_tbl[idx]   = '0;
                  retx_dl_tbl[idx] = t;
                end
              end
              ST_INCOMPLETE, ST_PROBE: begin
                probing = (cur == ST_PROBE);
                limit   = probing ? ucast_limit : mcast_limit;
                if (count_tbl[idx] >= limit) begin
                  valid_tbl[idx] = 1'b0;
                  res.action     = ACT_DROP;
                  res.chk        = probing;
                end else if (deadline_passed(t, retx_dl_tbl[idx]) && idle) begin
                  count_tbl[idx]   = count_tbl[idx] + 4'd1;
                  res.action       = probing ? ACT_UCAST : ACT_MCAST;
                  retx_dl_tbl[idx] = t + retx_secs;
                end
              end
              default: ;
            endcase
          end
        end
      end
    endcase
    if (valid_tbl[idx]) begin
      res.valid = 1'b1;
      res.state = state_tbl[idx];
      res.count = count_tbl[idx];
    end
  endtask

  always @(posedge clk) begin : watch
    nbr_outcome_t want;
    nbr_outcome_t fresh;
    if (rst) begin
      reach_secs  = REACHABLE_RESET;
      retx_secs   = RETRANS_RESET;
      mcast_limit = MAX_MCAST_RESET;
      ucast_limit = MAX_UCAST_RESET;
      foreach (valid_tbl[i]) valid_tbl[i] = 1'b0;
      outcome_q.delete();
    end else begin
      // compare the arriving beat before predicting one taken on this edge
      if (done === 1'b1) begin
        if (outcome_q.size() == 0) begin
          report_fault("result beat with nothing expected");
        end else begin
          want = outcome_q.pop_front();
          results_seen++;
          if (want.action == ACT_MCAST || want.action == ACT_UCAST) solicits_seen++;
          if (want.action == ACT_DROP) drops_seen++;
          if (entry_valid !== want.valid)
            report_fault($sformatf("entry_valid got %b want %b", entry_valid, want.valid));
          if (entry_state !== want.state)
            report_fault($sformatf("entry_state got %0d want %0d", entry_state, want.state));
          if (action !== want.action)
            report_fault($sformatf("action got %0d want %0d", action, want.action));
          if (check_default_router !== want.chk)
            report_fault($sformatf("check_default_router got %b want %b",
                                   check_default_router, want.chk));
          if (solicit_count !== want.count)
            report_fault($sformatf("solicit_count got %0d want %0d",
                                   solicit_count, want.count));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REACHABLE: reach_secs  = cfg_data;
          REG_RETRANS:   retx_secs   = cfg_data;
          REG_MAX_MCAST: mcast_limit = cfg_data[3:0];
          REG_MAX_UCAST: ucast_limit = cfg_data[3:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        step_entry(kind, entry, new_state, now_seconds, tx_idle, fresh);
        outcome_q.push_back(fresh);
      end
    end
    pending = outcome_q.size();
  end

endmodule

FILE: dv/neighbor_reachability_tracker_core_tb.sv
// testbench top for the neighbour reachability tracker: clock, reset, request and
// register stimulus, verdict; depends on nrt_pkg, the block and nrt_tracker_checker
module neighbor_reachability_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nrt_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASES        = 6;
  localparam int ITEMS_A_PHASE = 115;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = KIND_ADD;
  logic [3:0]  entry = '0;
  logic [2:0]  new_state = ST_INCOMPLETE;
  logic [31:0] now_seconds = '0;
  logic        tx_idle = 1'b0;
  logic        done;
  logic        entry_valid;
  logic [2:0]  entry_state;
  logic [1:0]  action;
  logic        check_default_router;
  logic [3:0]  solicit_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_REACHABLE;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int pending;
  int results_seen;
  int solicits_seen;
  int drops_seen;

  int        cycles = 0;
  int        items_sent = 0;
  int        sender_idle_pct = 0;
  bit [31:0] now_s = 32'h0000_1000;
  bit [15:0] ever_added = '0;

  neighbor_reachability_tracker_core dut (
    .clk                  (clk),
    .rst                  (rst),
    .start                (start),
    .busy                 (busy),
    .kind                 (kind),
    .entry                (entry),
    .new_state            (new_state),
    .now_seconds          (now_seconds),
    .tx_idle              (tx_idle),
    .done                 (done),
    .entry_valid          (entry_valid),
    .entry_state          (entry_state),
    .action               (action),
    .check_default_router (check_default_router),
    .solicit_count        (solicit_count),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  nrt_tracker_checker u_check (
    .clk                  (clk),
    .rst                  (rst),
    .start                (start),
    .busy                 (busy),
    .kind                 (kind),
    .entry                (entry),
    .new_state            (new_state),
    .now_seconds          (now_seconds),
    .tx_idle              (tx_idle),
    .done                 (done),
    .entry_valid          (entry_valid),
    .entry_state          (entry_state),
    .action               (action),
    .check_default_router (check_default_router),
    .solicit_count        (solicit_count),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .fail_count           (fail_count),
    .pending              (pending),
    .results_seen         (results_seen),
    .solicits_seen        (solicits_seen),
    .drops_seen           (drops_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding", cycles, pending);
      $display("FAIL neighbor_reachability_tracker_core");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that takes the request beat
  task automatic issue_request(input logic [1:0] k, input logic [3:0] e,
                               input logic [2:0] nst, input logic [31:0] t,
                               input logic idle);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    kind        <= k;
    entry       <= e;
    new_state   <= nst;
    now_seconds <= t;
    tx_idle     <= idle;
    start       <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    items_sent++;
    if (k == KIND_ADD && nst <= ST_PROBE) ever_added[e] = 1'b1;
  endtask

  // stop sending until every expected beat is back, then let the pipe settle
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high so consecutive writes run back to back
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_timers(input logic [15:0] reach, input logic [15:0] retx,
                            input logic [15:0] mcast, input logic [15:0] ucast);
    write_reg(REG_REACHABLE, reach);
    write_reg(REG_RETRANS, retx);
    write_reg(REG_MAX_MCAST, mcast);
    write_reg(REG_MAX_UCAST, ucast);
    cfg_valid <= 1'b0;
  endtask

  // mostly small steps so timers expire in order, now and then a long jump
  task automatic advance_clock();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
    end else if (r < 80) begin
      now_s += $urandom_range(3);
    end else if (r < 93) begin
      now_s += $urandom_range(40);
    end else if (r < 98) begin
      now_s += $urandom_range(70000);
    end else begin
      now_s = $urandom;
    end
  endtask

  task automatic random_item();
    logic [1:0] k;
    logic [3:0] e;
    logic [2:0] s;
    int         r;
    r = $urandom_range(99);
    e = ($urandom_range(9) < 7) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    if (r < 15)      k = KIND_ADD;
    else if (r < 20) k = KIND_REMOVE;
    else if (r < 40) k = KIND_ACK;
    else             k = KIND_CHECK;
    s = ($urandom_range(99) < 8) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    // only address records that an add has written
    if (!ever_added[e]) begin
      k = KIND_ADD;
      if (s > ST_PROBE) s = ST_INCOMPLETE;
    end
    advance_clock();
    issue_request(k, e, s, now_s, $urandom_range(9) < 8);
  endtask

  initial begin
    bit [31:0] t0;
    t0 = 32'h0000_1000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset timer settings: incomplete resolution until the multicast limit
    issue_request(KIND_ADD,   4'd0, ST_INCOMPLETE, t0, 1'b1);
    issue_request(KIND_CHECK, 4'd0, ST_INCOMPLETE, t0, 1'b0);
    issue_request(KIND_CHECK, 4'd0, ST_INCOMPLETE, t0, 1'b1);
    issue_request(KIND_CHECK, 4'd0, ST_INCOMPLETE, t0, 1'b1);
    issue_request(KIND_CHECK, 4'd0, ST_INCOMPLETE, t0 + 32'd1, 1'b1);
    issue_request(KIND_CHECK, 4'd0, ST_INCOMPLETE, t0 + 32'd2, 1'b1);
    issue_request(KIND_CHECK, 4'd0, ST_INCOMPLETE, t0 + 32'd3, 1'b1);
    issue_request(KIND_ACK,   4'd0, ST_INCOMPLETE, t0 + 32'd3, 1'b1);
    // probe confirmed by a link ack, then the reachable lifetime runs out
    issue_request(KIND_ADD,   4'd1, ST_PROBE, t0, 1'b1);
    issue_request(KIND_CHECK, 4'd1, ST_PROBE, t0, 1'b1);
    issue_request(KIND_ACK,   4'd1, ST_PROBE, t0, 1'b1);
    issue_request(KIND_CHECK, 4'd1, ST_PROBE, t0 + 32'd29, 1'b1);
    issue_request(KIND_CHECK, 4'd1, ST_PROBE, t0 + 32'd30, 1'b1);
    // half-range edge of the wrap-safe compare
    issue_request(KIND_ADD,   4'd2, ST_REACHABLE, t0, 1'b1);
    issue_request(KIND_CHECK, 4'd2, ST_REACHABLE, t0 + 32'h7FFF_FFFF, 1'b1);
    issue_request(KIND_CHECK, 4'd2, ST_REACHABLE, t0 + 32'h7FFF_FFFE, 1'b1);
    // delay expiring across the wrap of the seconds counter
    issue_request(KIND_ADD,   4'd15, ST_DELAY, 32'hFFFF_FFFF, 1'b1);
    issue_request(KIND_CHECK, 4'd15, ST_DELAY, 32'h0000_0000, 1'b0);
    // unknown state codes on add are ignored
    issue_request(KIND_ADD,   4'd15, 3'd5, 32'h0000_0000, 1'b1);
    issue_request(KIND_ADD,   4'd15, 3'd7, 32'h0000_0000, 1'b1);
    // stale confirmed, second ack on reachable is a no-op, then removal
    issue_request(KIND_ADD,    4'd3, ST_STALE, t0, 1'b1);
    issue_request(KIND_ACK,    4'd3, ST_STALE, t0, 1'b1);
    issue_request(KIND_ACK,    4'd3, ST_STALE, t0, 1'b1);
    issue_request(KIND_REMOVE, 4'd3, ST_STALE, t0, 1'b1);
    now_s = t0 + 32'd40;

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: set_timers(16'd5, 16'd1, 16'd3, 16'd3);
        1: set_timers(16'd0, 16'd0, 16'd0, 16'd0);
        2: set_timers(16'hFFFF, 16'hFFFF, 16'd15, 16'd15);
        3: set_timers(16'($urandom_range(1, 20)), 16'($urandom_range(4)),
                      16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
        4: set_timers(16'($urandom_range(1, 8)), 16'($urandom_range(2)),
                      16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)));
        // upper data bits are don't-care for the 4-bit limits
        default: set_timers(16'($urandom), 16'($urandom_range(200)),
                            16'($urandom), 16'($urandom));
      endcase
      case (ph % 3)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 76;
        default: sender_idle_pct = 37;
      endcase
      for (int n = 0; n < ITEMS_A_PHASE; n++) begin
        random_item();
        if (ph == 3 && n == ITEMS_A_PHASE / 2) drain();
      end
    end
    drain();

    $display("%0d requests over %0d timer and limit settings plus the reset values",
             items_sent, PHASES);
    $display("%0d result beats checked, %0d solicitations and %0d drops among them",
             results_seen, solicits_seen, drops_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS neighbor_reachability_tracker_core");
    end else begin
      $display("FAIL neighbor_reachability_tracker_core");
    end
    $finish;
  end

endmodule

FILE: files.f
src/nrt_pkg.sv
src/nrt_entry_store.sv
src/nrt_step.sv
src/neighbor_reachability_tracker_core.sv
src/nrt_checker.sv
dv/nrt_tracker_checker.sv
dv/neighbor_reachability_tracker_core_tb.sv
